// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// prop must hold at every clock edge outside reset
`define ASSERT_HOLDS(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// cons must hold in the cycle after ante
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_HOLDS(lbl, clk, rst, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// ===== rtl/bmhq_pkg.sv =====
// ----------------------------------------------------------------------------
// bmhq_pkg
// Shared types and constants of the bounded min-heap queue.
// ----------------------------------------------------------------------------
package bmhq_pkg;

  localparam int DEFAULT_CAPACITY = 1024;

  localparam int PRIO_W  = 32;
  localparam int TAG_W   = 32;
  localparam int COUNT_W = 11;
  localparam int LIMIT_W = 11;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;

  // APB register map
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic REG_QUEUE_LIMIT = 1'b0;  // word index, paddr[2]

  // operation codes carried in tuser
  localparam logic FUNC_ENQUEUE = 1'b0;
  localparam logic FUNC_DEQUEUE = 1'b1;

  localparam logic [TAG_W-1:0]         NONE_TAG  = '0;
  localparam logic signed [PRIO_W-1:0] NONE_PRIO = -32'sd1;

  typedef struct packed {
    logic [TAG_W-1:0]         tag;
    logic signed [PRIO_W-1:0] prio;
  } item_t;

  typedef struct packed {
    logic                     removed;
    logic [TAG_W-1:0]         tag;
    logic signed [PRIO_W-1:0] prio;
    logic [COUNT_W-1:0]       count;
  } result_t;

endpackage

// ===== rtl/bmhq_ram.sv =====
// ----------------------------------------------------------------------------
// bmhq_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bmhq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1026
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/bmhq_cfg.sv =====
// ----------------------------------------------------------------------------
// bmhq_cfg
// APB register block holding the queue limit.
// ----------------------------------------------------------------------------
module bmhq_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bmhq_pkg::APB_AW-1:0]       paddr,
  input  logic [bmhq_pkg::APB_DW-1:0]       pwdata,
  output logic [bmhq_pkg::APB_DW-1:0]       prdata,
  output logic                              pready,
  output logic [bmhq_pkg::LIMIT_W-1:0]      queue_limit
);

  logic sel_limit;

  assign pready    = 1'b1;
  assign sel_limit = (paddr[2] == bmhq_pkg::REG_QUEUE_LIMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      queue_limit <= bmhq_pkg::LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && sel_limit) begin
      queue_limit <= pwdata[bmhq_pkg::LIMIT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (sel_limit) begin
      prdata = {{(bmhq_pkg::APB_DW - bmhq_pkg::LIMIT_W){1'b0}}, queue_limit};
    end
  end

endmodule

// ===== rtl/bmhq_core.sv =====
// ----------------------------------------------------------------------------
// bmhq_core
// Heap sequencer: sift-up, root removal and sift-down over one item RAM.
// ----------------------------------------------------------------------------
module bmhq_core #(
  parameter int CAPACITY = bmhq_pkg::DEFAULT_CAPACITY
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_func,
  input  bmhq_pkg::item_t               in_item,
  input  logic [bmhq_pkg::LIMIT_W-1:0]  limit,
  output logic                          res_valid,
  input  logic                          res_ready,
  output bmhq_pkg::result_t             res
);

  localparam int DEPTH = CAPACITY + 2;
  localparam int AW    = $clog2(DEPTH);
  // count briefly reaches CAPACITY + 1 before an eviction
  localparam int CW    = $clog2(CAPACITY + 2);
  localparam int XW    = AW + 1;
  localparam int CMPW  = (CW > bmhq_pkg::LIMIT_W) ? CW : bmhq_pkg::LIMIT_W;
  localparam logic [AW-1:0] ROOT = AW'(1);

  typedef enum logic [9:0] {
    ST_IDLE     = 10'b0000000001,
    ST_UP_RD    = 10'b0000000010,
    ST_UP_CMP   = 10'b0000000100,
    ST_POP_ROOT = 10'b0000001000,
    ST_POP_LAST = 10'b0000010000,
    ST_POP_LOAD = 10'b0000100000,
    ST_DN_RDL   = 10'b0001000000,
    ST_DN_RDR   = 10'b0010000000,
    ST_DN_CMP   = 10'b0100000000,
    ST_RESULT   = 10'b1000000000
  } state_t;

  state_t            state;
  logic [CW-1:0]     occ;
  logic [AW-1:0]     idx;
  bmhq_pkg::item_t   cur;       // item being moved; its slot is the hole at idx
  bmhq_pkg::item_t   left;
  logic              right_rd;
  logic              got;
  bmhq_pkg::item_t   rem;

  logic                          wr_en;
  logic [AW-1:0]                 wr_addr;
  bmhq_pkg::item_t               wr_item;
  logic                          rd_en;
  logic [AW-1:0]                 rd_addr;
  logic [$bits(bmhq_pkg::item_t)-1:0] rd_data;
  bmhq_pkg::item_t               rd_item;

  logic [AW-1:0]   parent;
  logic [XW-1:0]   child_l;
  logic [XW-1:0]   child_r;
  logic [XW-1:0]   occ_x;
  logic            have_left;
  logic            have_right;
  logic            right_better;
  bmhq_pkg::item_t best;
  logic [AW-1:0]   best_idx;
  logic            sink_stop;
  logic            rise_stop;
  logic [CMPW-1:0] limit_ext;
  logic [CMPW-1:0] limit_eff;
  logic            over_limit;

  bmhq_ram #(
    .WIDTH ($bits(bmhq_pkg::item_t)),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_item),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_item = bmhq_pkg::item_t'(rd_data);

  assign parent       = idx >> 1;
  assign child_l      = {idx, 1'b0};
  assign child_r      = {idx, 1'b1};
  assign occ_x        = {{(XW - CW){1'b0}}, occ};
  assign have_left    = (child_l <= occ_x);
  assign have_right   = (child_r <= occ_x);
  // ties between children keep the left one
  assign right_better = right_rd && (rd_item.prio < left.prio);
  assign best         = right_better ? rd_item : left;
  assign best_idx     = right_better ? child_r[AW-1:0] : child_l[AW-1:0];
  assign sink_stop    = (cur.prio <= best.prio);
  assign rise_stop    = !(rd_item.prio > cur.prio);

  assign limit_ext  = CMPW'(limit);
  assign limit_eff  = (limit_ext > CMPW'(CAPACITY)) ? CMPW'(CAPACITY) : limit_ext;
  assign over_limit = (CMPW'(occ) > limit_eff);

  assign in_ready  = (state == ST_IDLE);
  assign res_valid = (state == ST_RESULT);

  always_comb begin
    res.removed = got;
    res.tag     = got ? rem.tag  : bmhq_pkg::NONE_TAG;
    res.prio    = got ? rem.prio : bmhq_pkg::NONE_PRIO;
    res.count   = bmhq_pkg::COUNT_W'(occ);
  end

  // RAM port control
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx;
    wr_item = cur;
    rd_en   = 1'b0;
    rd_addr = parent;
    unique case (state)
      ST_UP_RD: begin
        if (idx == ROOT) begin
          wr_en = 1'b1;
        end else begin
          rd_en = 1'b1;
        end
      end
      ST_UP_CMP: begin
        wr_en = 1'b1;
        if (!rise_stop) begin
          wr_item = rd_item;
        end
      end
      ST_POP_ROOT: begin
        rd_en   = 1'b1;
        rd_addr = ROOT;
      end
      ST_POP_LAST: begin
        rd_en   = 1'b1;
        rd_addr = AW'(occ);
      end
      ST_DN_RDL: begin
        if (have_left) begin
          rd_en   = 1'b1;
          rd_addr = child_l[AW-1:0];
        end else begin
          wr_en = 1'b1;
        end
      end
      ST_DN_RDR: begin
        rd_en   = have_right;
        rd_addr = child_r[AW-1:0];
      end
      ST_DN_CMP: begin
        wr_en = 1'b1;
        if (!sink_stop) begin
          wr_item = best;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      occ   <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            got <= 1'b0;
            if (in_func == bmhq_pkg::FUNC_ENQUEUE) begin
              cur   <= in_item;
              occ   <= occ + CW'(1);
              idx   <= AW'(occ) + AW'(1);
              state <= ST_UP_RD;
            end else if (occ == '0) begin
              state <= ST_RESULT;
            end else begin
              state <= ST_POP_ROOT;
            end
          end
        end
        ST_UP_RD: begin
          if (idx == ROOT) begin
            state <= over_limit ? ST_POP_ROOT : ST_RESULT;
          end else begin
            state <= ST_UP_CMP;
          end
        end
        ST_UP_CMP: begin
          if (rise_stop) begin
            state <= over_limit ? ST_POP_ROOT : ST_RESULT;
          end else begin
            idx   <= parent;
            state <= ST_UP_RD;
          end
        end
        ST_POP_ROOT: begin
          state <= ST_POP_LAST;
        end
        ST_POP_LAST: begin
          rem   <= rd_item;
          got   <= 1'b1;
          state <= ST_POP_LOAD;
        end
        ST_POP_LOAD: begin
          cur   <= rd_item;
          occ   <= occ - CW'(1);
          idx   <= ROOT;
          state <= (occ == CW'(1)) ? ST_RESULT : ST_DN_RDL;
        end
        ST_DN_RDL: begin
          state <= have_left ? ST_DN_RDR : ST_RESULT;
        end
        ST_DN_RDR: begin
          left     <= rd_item;
          right_rd <= have_right;
          state    <= ST_DN_CMP;
        end
        ST_DN_CMP: begin
          if (sink_stop) begin
            state <= ST_RESULT;
          end else begin
            idx   <= best_idx;
            state <= ST_DN_RDL;
          end
        end
        ST_RESULT: begin
          if (res_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/bounded_min_heap_queue_top.sv =====
// ----------------------------------------------------------------------------
// bounded_min_heap_queue_top
// Bounded min-heap priority queue with stream request/result ports and APB.
// ----------------------------------------------------------------------------
// One request at a time: a new request is taken only once the previous
// result has been passed to the output register. An enqueue sifts up; a
// dequeue removes the root and sifts down. An enqueue that goes over the
// limit then evicts the root as a dequeue would. A stalled result stretches
// an operation by the stall. Each sift-up level costs a read and a write of
// the single item RAM, each sift-down level up to two reads and a write, and
// the registered RAM read sets the pace. An evicted or dequeued item is
// reported with removed set; otherwise removed_tag is 0 and removed_priority
// is -1. The queue limit saturates at CAPACITY; the user must see that it is
// written only while the queue is idle, as the block itself does not enforce
// this. No clearing pass: the heap RAM needs none.

`include "assert_macros.svh"

module bounded_min_heap_queue_top #(
  parameter int CAPACITY = bmhq_pkg::DEFAULT_CAPACITY
) (
  input  logic                        clk,
  input  logic                        rst,
  // request stream
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [63:0]                 s_tdata,   // [31:0] priority_req, [63:32] tag
  input  logic                        s_tuser,   // [0] func
  // result stream
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [79:0]                 m_tdata,   // [31:0] removed_tag,
                                                 // [63:32] removed_priority,
                                                 // [74:64] item_count, rest zero
  output logic                        m_tuser,   // [0] removed
  // APB configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bmhq_pkg::APB_AW-1:0] paddr,
  input  logic [bmhq_pkg::APB_DW-1:0] pwdata,
  output logic [bmhq_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);

  logic [bmhq_pkg::LIMIT_W-1:0] queue_limit;
  bmhq_pkg::item_t              in_item;
  bmhq_pkg::result_t            res;
  bmhq_pkg::result_t            out_res;
  logic                         res_valid;
  logic                         res_ready;

  bmhq_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .queue_limit (queue_limit)
  );

  assign in_item.prio = s_tdata[31:0];
  assign in_item.tag  = s_tdata[63:32];

  bmhq_core #(
    .CAPACITY (CAPACITY)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_func   (s_tuser),
    .in_item   (in_item),
    .limit     (queue_limit),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register decouples the result from the sequencer
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res <= res;
    end
  end

  assign m_tdata = {{(80 - 32 - 32 - bmhq_pkg::COUNT_W){1'b0}},
                    out_res.count, out_res.prio, out_res.tag};
  assign m_tuser = out_res.removed;

  `ASSERT_HOLDS(a_busy_while_result, clk, rst, res_valid |-> !s_tready, "request taken while a result is pending")
  `ASSERT_NEXT(a_one_request, clk, rst, s_tvalid && s_tready, !s_tready, "second request taken before the first finished")
  `ASSERT_HOLDS(a_none_fields, clk, rst, (m_tvalid && !m_tuser) |-> (m_tdata[31:0] == 32'd0 && m_tdata[63:32] == 32'hFFFFFFFF), "empty result carries stale item fields")

endmodule
